/* rtl/core/price_time_priority_book_side_assert.svh */
// Assertion macros used by the order book side top level.
`ifndef PRICE_TIME_PRIORITY_BOOK_SIDE_ASSERT_SVH
`define PRICE_TIME_PRIORITY_BOOK_SIDE_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define PBS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PBS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define PBS_ASSERT(lbl, clk, rst_n, prop, msg)
`define PBS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

/* rtl/core/pbs_pkg.sv */
// Types and constants of the order book side.
package pbs_pkg;

    localparam int BOOK_DEPTH = 64;
    localparam int CNT_W      = $clog2(BOOK_DEPTH + 1);
    localparam int PRICE_W    = 32;
    localparam int ID_W       = 64;
    localparam int OUT_CNT_W  = 7;
    localparam int IN_DATA_W  = ID_W + PRICE_W;
    localparam int OUT_DATA_W = 1 + PRICE_W + ID_W + OUT_CNT_W;

    typedef enum logic {
        CMD_ADD    = 1'b0,
        CMD_REMOVE = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } state_t;

    typedef struct packed {
        logic               valid;
        logic [PRICE_W-1:0] price;
        logic [ID_W-1:0]    id;
    } entry_t;

    typedef struct packed {
        logic               active;
        cmd_t               cmd;
        logic               hit;
        logic               carry_valid;
        logic [PRICE_W-1:0] price;
        logic [ID_W-1:0]    id;
    } wave_t;

endpackage

/* rtl/core/pbs_cell.sv */
// One slot of the sorted order chain, acting on the command wave as it passes.
module pbs_cell
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            sort_desc,
    input  pbs_pkg::wave_t  wave_in,
    input  pbs_pkg::entry_t nxt,
    output pbs_pkg::wave_t  wave_out,
    output pbs_pkg::entry_t ent
);
    import pbs_pkg::*;

    logic               valid_reg;
    logic               valid_next;
    logic [PRICE_W-1:0] price_reg;
    logic [PRICE_W-1:0] price_next;
    logic [ID_W-1:0]    id_reg;
    logic [ID_W-1:0]    id_next;
    wave_t              wave_reg;
    wave_t              wave_next;
    logic               worse;
    logic               hit;

    always_comb
    begin
        worse      = sort_desc ? (price_reg < wave_in.price) : (price_reg > wave_in.price);
        hit        = 1'b0;
        wave_next  = wave_in;
        valid_next = valid_reg;
        price_next = price_reg;
        id_next    = id_reg;
        if (wave_in.active)
        begin
            case (wave_in.cmd)
                CMD_ADD:
                begin
                    hit = wave_in.hit | ~valid_reg | worse;
                    if (hit && wave_in.carry_valid)
                    begin
                        // insert carried order, pass displaced one down
                        valid_next            = 1'b1;
                        price_next            = wave_in.price;
                        id_next               = wave_in.id;
                        wave_next.price       = price_reg;
                        wave_next.id          = id_reg;
                        wave_next.carry_valid = valid_reg;
                    end
                end
                CMD_REMOVE:
                begin
                    hit = wave_in.hit | (valid_reg && (id_reg == wave_in.id));
                    if (hit)
                    begin
                        // close the gap from the neighbour behind
                        valid_next = nxt.valid;
                        price_next = nxt.price;
                        id_next    = nxt.id;
                    end
                end
                default:
                begin
                    hit = wave_in.hit;
                end
            endcase
            wave_next.hit = hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            wave_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            wave_reg  <= wave_next;
        end
    end

    always_ff @(posedge clk)
    begin
        price_reg <= price_next;
        id_reg    <= id_next;
    end

    assign wave_out  = wave_reg;
    assign ent.valid = valid_reg;
    assign ent.price = price_reg;
    assign ent.id    = id_reg;

endmodule

/* rtl/core/price_time_priority_book_side.sv */
// Top level of one order book side: input stage, cell chain and result register.
// An input item passes through the input register, the cell chain and the result register.
// The block handles one item at a time; the command wave walks the chain
// one cell per cycle and the next item is taken once the result is registered.
// Reset (rst_n, asynchronous, active low) empties the book and selects ascending order.
`include "price_time_priority_book_side_assert.svh"

module price_time_priority_book_side
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic                           cfg_data,   // sort_descending
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [pbs_pkg::IN_DATA_W-1:0]  s_tdata,    // ord_id, price
    input  logic                           s_tuser,    // command
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [pbs_pkg::OUT_DATA_W-1:0] m_tdata,    // best_valid, best_price_out,
                                                       // best_id, order_count
    output logic [1:0]                     m_tuser     // status
);
    import pbs_pkg::*;

    state_t                state_reg;
    state_t                state_next;
    logic                  sort_desc_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    wave_t                 launch_reg;
    cmd_t                  cmd_reg;
    logic                  drop_reg;
    logic                  hit_reg;
    logic                  m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic [1:0]            m_tuser_reg;
    status_t               status;
    logic                  accept;
    logic                  load;
    logic                  full;
    wave_t                 waves [BOOK_DEPTH];
    entry_t                ents  [BOOK_DEPTH];
    logic [BOOK_DEPTH-1:0] valid_vec;

    genvar g;
    generate
        for (g = 0; g < BOOK_DEPTH; g++)
        begin : g_cell
            wave_t  w_in;
            entry_t e_nxt;
            if (g == 0)
            begin : g_first
                assign w_in = launch_reg;
            end
            else
            begin : g_rest
                assign w_in = waves[g-1];
            end
            if (g == BOOK_DEPTH - 1)
            begin : g_last
                assign e_nxt = '0;
            end
            else
            begin : g_inner
                assign e_nxt = ents[g+1];
            end
            pbs_cell u_cell
            (
                .clk       (clk),
                .rst_n     (rst_n),
                .sort_desc (sort_desc_reg),
                .wave_in   (w_in),
                .nxt       (e_nxt),
                .wave_out  (waves[g]),
                .ent       (ents[g])
            );
            assign valid_vec[g] = ents[g].valid;
        end
    endgenerate

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign full      = (count_reg == CNT_W'(BOOK_DEPTH));
    assign load      = (state_reg == S_DONE) && (!m_tvalid_reg || m_tready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                if (waves[BOOK_DEPTH-1].active)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        status     = ST_OK;
        if (cmd_reg == CMD_ADD)
        begin
            if (drop_reg)
            begin
                status = ST_FULL;
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
        else
        begin
            if (hit_reg)
            begin
                count_next = count_reg - CNT_W'(1);
            end
            else
            begin
                status = ST_NOT_FOUND;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sort_desc_reg <= 1'b0;
            count_reg     <= '0;
            launch_reg    <= '0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            launch_reg.active <= accept;
            if (accept)
            begin
                launch_reg.cmd         <= cmd_t'(s_tuser);
                launch_reg.hit         <= 1'b0;
                launch_reg.carry_valid <= (cmd_t'(s_tuser) == CMD_ADD) && !full;
                launch_reg.id          <= s_tdata[ID_W-1:0];
                launch_reg.price       <= s_tdata[IN_DATA_W-1:ID_W];
            end
            if (cfg_valid && cfg_ready)
            begin
                sort_desc_reg <= cfg_data;
            end
            if (load)
            begin
                count_reg    <= count_next;
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= cmd_t'(s_tuser);
            drop_reg <= full;
        end
        if (waves[BOOK_DEPTH-1].active)
        begin
            hit_reg <= waves[BOOK_DEPTH-1].hit;
        end
        if (load)
        begin
            m_tuser_reg <= status;
            m_tdata_reg <= {OUT_CNT_W'(count_next),
                            ents[0].valid ? ents[0].id : {ID_W{1'b0}},
                            ents[0].valid ? ents[0].price : {PRICE_W{1'b0}},
                            ents[0].valid};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `PBS_ASSERT(a_valid_prefix, clk, rst_n, ((valid_vec + BOOK_DEPTH'(1)) & valid_vec) == '0, "held slots not a prefix")
    `PBS_ASSERT(a_count_match, clk, rst_n, (state_reg == S_IDLE) |-> ($countones(valid_vec) == count_reg), "order count disagrees with held slots")
    `PBS_ASSERT(a_accept_busy, clk, rst_n, accept |=> (state_reg == S_RUN), "item accepted without starting the wave")
    `PBS_ASSERT(a_done_loads, clk, rst_n, $fell(state_reg == S_DONE) |-> m_tvalid_reg, "item finished without a result")
    `PBS_ASSERT_NEVER(a_one_wave, clk, rst_n, !$onehot0({launch_reg.active, waves[BOOK_DEPTH-1].active}) || (launch_reg.active && (state_reg != S_RUN)), "wave overlap")

endmodule
